// ===== hw/rtl/slu_pkg.sv =====
`default_nettype none

package slu_pkg;

  // Characters the decoder reacts to.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChApos      = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowU      = 8'h75;
  localparam logic [7:0] ChLBrace    = 8'h7B;
  localparam logic [7:0] ChRBrace    = 8'h7D;
  localparam logic [7:0] ChUnder     = 8'h5F;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDel       = 8'h7F;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;

  // Code point limits.
  localparam logic [20:0] CpSurrLo  = 21'h00D800;
  localparam logic [20:0] CpSurrHi  = 21'h00E000;
  localparam logic [24:0] CpLimit   = 25'h0110000;
  localparam logic [20:0] CpOneMax  = 21'h000080;
  localparam logic [20:0] CpTwoMax  = 21'h000800;
  localparam logic [20:0] CpThreeMax = 21'h010000;

  typedef enum logic [3:0] {
    M_IDLE,
    M_BODY,
    M_ESC,
    M_HEX2,
    M_UOPEN,
    M_UFIRST,
    M_UDIGITS,
    M_UUNDER,
    M_DONE,
    M_DISCARD
  } mode_t;

  typedef enum logic [2:0] {
    ST_BYTE,
    ST_CLOSED,
    ST_NOQUOTE,
    ST_UNTERM,
    ST_CONTROL,
    ST_BADESC,
    ST_BADUNI,
    ST_RANGE
  } status_t;

  // Results caused by one input beat: cnt of zero means none.
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
    status_t         status;
  } grp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/string_literal_unescaper_top.sv =====
// Channel  Direction  tdata (low bit up)                  tlast
// s_*      in         in_byte[7:0]                        end_of_input
// m_*      out        out_byte[7:0], status[10:8], zero   last
//
// A beat is held in the input register, then is decoded into the result register,
// which sends its one to four result beats one per cycle while m_tready is high.
// A new input beat is taken every cycle while each beat gives at most one result
// and m_tready is high; a unicode escape that closes sends up to four beats.
// Reset is synchronous and returns the decoder to waiting for an opening quote.
// A stall on m_* holds the result register, then the input register, then s_tready.
`default_nettype none

module string_literal_unescaper_top
  import slu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_byte[7:0]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // out_byte[7:0], status[10:8], zeros
  output logic             m_tlast
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eoi;
  logic       adv;
  logic       load;
  logic       free;
  logic [1:0] idx;
  logic [2:0] cnt;
  grp_t       grp;
  mode_t      mode;

  // A beat that makes no result leaves the input register without waiting.
  assign adv      = in_valid && (grp.cnt == 3'd0 || free);
  assign load     = adv && grp.cnt != 3'd0;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tlast;
    end
  end

  slu_core u_core (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_byte (in_byte),
    .eoi     (in_eoi),
    .grp     (grp),
    .mode    (mode)
  );

  slu_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .grp_in   (grp),
    .free     (free),
    .idx      (idx),
    .cnt      (cnt),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result group loaded over one still in flight");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, idx} < cnt))
    else $error("result index past group length");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[10:8] != ST_BYTE) |-> m_tlast)
    else $error("status beat is not the last of its group");

  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && in_eoi) |=> (mode == M_IDLE))
    else $error("end of input did not return decoder to idle");

endmodule

`default_nettype wire

// ===== hw/rtl/slu_core.sv =====
`default_nettype none

module slu_core
  import slu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic [7:0] in_byte,
  input  wire logic       eoi,
  output grp_t            grp,
  output mode_t           mode
);

  logic [3:0]  hex_high_nibble;
  logic [20:0] code_point;
  logic        too_large;

  mode_t       mode_next;
  logic [3:0]  hex_high_nibble_next;
  logic [20:0] code_point_next;
  logic        too_large_next;

  logic        is_hex;
  logic [3:0]  hval;
  logic [24:0] acc;
  logic        acc_big;
  logic        cp_bad;

  always_comb begin
    is_hex = 1'b1;
    hval   = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hval = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hval = 4'(in_byte - 8'h37);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hval = 4'(in_byte - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign acc     = {code_point, 4'b0000} + {21'd0, hval};
  assign acc_big = acc >= CpLimit;
  assign cp_bad  = too_large || ({4'd0, code_point} >= CpLimit) ||
                   (code_point >= CpSurrLo && code_point < CpSurrHi);

  // Next state.
  always_comb begin
    mode_next            = mode;
    hex_high_nibble_next = hex_high_nibble;
    code_point_next      = code_point;
    too_large_next       = too_large;
    if (eoi) begin
      mode_next            = M_IDLE;
      hex_high_nibble_next = 4'd0;
      code_point_next      = 21'd0;
      too_large_next       = 1'b0;
    end else begin
      unique case (mode) inside
        M_IDLE: begin
          mode_next = (in_byte == ChQuote) ? M_BODY : M_DISCARD;
        end
        M_BODY: begin
          if (in_byte == ChQuote) begin
            mode_next = M_DONE;
          end else if (in_byte == ChBackslash) begin
            mode_next = M_ESC;
          end else if (in_byte < ChSpace || in_byte == ChDel) begin
            mode_next = M_DISCARD;
          end
        end
        M_ESC: begin
          if (in_byte == ChLowT || in_byte == ChLowN || in_byte == ChLowR ||
              in_byte == ChBackslash || in_byte == ChQuote || in_byte == ChApos) begin
            mode_next = M_BODY;
          end else if (in_byte == ChLowU) begin
            mode_next = M_UOPEN;
          end else if (is_hex) begin
            hex_high_nibble_next = hval;
            mode_next            = M_HEX2;
          end else begin
            mode_next = M_DISCARD;
          end
        end
        M_HEX2: begin
          mode_next = is_hex ? M_BODY : M_DISCARD;
        end
        M_UOPEN: begin
          if (in_byte == ChLBrace) begin
            code_point_next = 21'd0;
            too_large_next  = 1'b0;
            mode_next       = M_UFIRST;
          end else begin
            mode_next = M_DISCARD;
          end
        end
        M_UFIRST, M_UUNDER, M_UDIGITS: begin
          if (is_hex) begin
            if (!too_large) begin
              if (acc_big) too_large_next = 1'b1;
              else code_point_next = acc[20:0];
            end
            mode_next = M_UDIGITS;
          end else if (mode == M_UDIGITS && in_byte == ChUnder) begin
            mode_next = M_UUNDER;
          end else if (mode == M_UDIGITS && in_byte == ChRBrace) begin
            mode_next = cp_bad ? M_DISCARD : M_BODY;
          end else begin
            mode_next = M_DISCARD;
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  // Results of this beat.
  always_comb begin
    grp        = '0;
    grp.status = ST_BYTE;
    if (eoi) begin
      if (mode == M_IDLE) begin
        grp.cnt    = 3'd1;
        grp.status = ST_NOQUOTE;
      end else if (mode != M_DONE && mode != M_DISCARD) begin
        grp.cnt    = 3'd1;
        grp.status = ST_UNTERM;
      end
    end else begin
      unique case (mode) inside
        M_IDLE: begin
          if (in_byte != ChQuote) begin
            grp.cnt    = 3'd1;
            grp.status = ST_NOQUOTE;
          end
        end
        M_BODY: begin
          if (in_byte == ChQuote) begin
            grp.cnt    = 3'd1;
            grp.status = ST_CLOSED;
          end else if (in_byte == ChBackslash) begin
            grp.cnt = 3'd0;
          end else if (in_byte < ChSpace || in_byte == ChDel) begin
            grp.cnt    = 3'd1;
            grp.status = ST_CONTROL;
          end else begin
            grp.cnt      = 3'd1;
            grp.bytes[0] = in_byte;
          end
        end
        M_ESC: begin
          if (in_byte == ChLowT) begin
            grp.cnt      = 3'd1;
            grp.bytes[0] = ChTab;
          end else if (in_byte == ChLowN) begin
            grp.cnt      = 3'd1;
            grp.bytes[0] = ChLf;
          end else if (in_byte == ChLowR) begin
            grp.cnt      = 3'd1;
            grp.bytes[0] = ChCr;
          end else if (in_byte == ChBackslash || in_byte == ChQuote ||
                       in_byte == ChApos) begin
            grp.cnt      = 3'd1;
            grp.bytes[0] = in_byte;
          end else if (in_byte != ChLowU && !is_hex) begin
            grp.cnt    = 3'd1;
            grp.status = ST_BADESC;
          end
        end
        M_HEX2: begin
          grp.cnt = 3'd1;
          if (is_hex) grp.bytes[0] = {hex_high_nibble, hval};
          else grp.status = ST_BADESC;
        end
        M_UOPEN: begin
          if (in_byte != ChLBrace) begin
            grp.cnt    = 3'd1;
            grp.status = ST_BADESC;
          end
        end
        M_UFIRST, M_UUNDER, M_UDIGITS: begin
          if (is_hex) begin
            grp.cnt = 3'd0;
          end else if (mode == M_UDIGITS && in_byte == ChUnder) begin
            grp.cnt = 3'd0;
          end else if (mode == M_UDIGITS && in_byte == ChRBrace) begin
            if (cp_bad) begin
              grp.cnt    = 3'd1;
              grp.status = ST_RANGE;
            end else if (code_point < CpOneMax) begin
              grp.cnt      = 3'd1;
              grp.bytes[0] = code_point[7:0];
            end else if (code_point < CpTwoMax) begin
              grp.cnt      = 3'd2;
              grp.bytes[0] = {3'b110, code_point[10:6]};
              grp.bytes[1] = {2'b10, code_point[5:0]};
            end else if (code_point < CpThreeMax) begin
              grp.cnt      = 3'd3;
              grp.bytes[0] = {4'b1110, code_point[15:12]};
              grp.bytes[1] = {2'b10, code_point[11:6]};
              grp.bytes[2] = {2'b10, code_point[5:0]};
            end else begin
              grp.cnt      = 3'd4;
              grp.bytes[0] = {5'b11110, code_point[20:18]};
              grp.bytes[1] = {2'b10, code_point[17:12]};
              grp.bytes[2] = {2'b10, code_point[11:6]};
              grp.bytes[3] = {2'b10, code_point[5:0]};
            end
          end else begin
            grp.cnt    = 3'd1;
            grp.status = ST_BADUNI;
          end
        end
        default: begin
          grp.cnt = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= M_IDLE;
      hex_high_nibble <= 4'd0;
      code_point      <= 21'd0;
      too_large       <= 1'b0;
    end else if (adv) begin
      mode            <= mode_next;
      hex_high_nibble <= hex_high_nibble_next;
      code_point      <= code_point_next;
      too_large       <= too_large_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slu_out.sv =====
`default_nettype none

module slu_out
  import slu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire grp_t        grp_in,
  output logic             free,
  output logic [1:0]       idx,
  output logic [2:0]       cnt,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tlast
);

  logic valid;
  grp_t grp;
  logic take;

  assign cnt      = grp.cnt;
  assign m_tvalid = valid;
  assign m_tlast  = ({1'b0, idx} == grp.cnt - 3'd1);
  assign m_tdata  = {5'd0, grp.status, grp.bytes[idx]};
  assign take     = valid && m_tready;
  // The register frees up in the same cycle its final beat is taken.
  assign free     = !valid || (take && m_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (take) begin
      if (m_tlast) valid <= 1'b0;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) grp <= grp_in;
  end

endmodule

`default_nettype wire

// ===== test/string_literal_unescaper_top_test.sv =====
`timescale 1ns / 1ps

module string_literal_unescaper_top_test;
  import slu_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int UsefulItems = 470;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
    logic [7:0] t_byte;
    status_t    t_status;
  } beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       last;
  } res_t;

  typedef enum {FLAW_NONE, FLAW_NO_QUOTE, FLAW_OPEN_END, FLAW_BAD_PIECE} flaw_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;

  string_literal_unescaper_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Decoder state as the predictor sees it.
  mode_t       lit_mode = M_IDLE;
  logic [3:0]  hi_nib = '0;
  logic [20:0] cp_acc = '0;
  logic        cp_huge = 1'b0;
  res_t        step_res [4];
  int          step_n;

  beat_t offered_q [$];
  res_t  decoded_q [$];
  beat_t literal_q [$];
  int    mismatches = 0;
  int    useful_in = 0;
  int    cycle_cnt = 0;

  // Rows with a typed result expect exactly that one result beat.
  beat_t directed_rows [28] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00, ST_NOQUOTE},
    '{ChQuote, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{ChSpace, 1'b0, 1'b1, ChSpace, ST_BYTE},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, ST_BYTE},
    '{ChBackslash, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h41, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h62, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{ChBackslash, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{ChLowU, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{ChLBrace, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h31, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h30, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{ChUnder, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h46, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h66, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h46, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h66, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{ChRBrace, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{ChQuote, 1'b0, 1'b1, 8'h00, ST_CLOSED},
    '{8'h61, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h5A, 1'b1, 1'b0, 8'h00, ST_BYTE},
    '{ChQuote, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'h1F, 1'b0, 1'b1, 8'h00, ST_CONTROL},
    '{8'h00, 1'b1, 1'b0, 8'h00, ST_BYTE},
    '{ChQuote, 1'b0, 1'b0, 8'h00, ST_BYTE},
    '{8'hA5, 1'b1, 1'b1, 8'h00, ST_UNTERM},
    '{8'h00, 1'b0, 1'b1, 8'h00, ST_NOQUOTE},
    '{8'hFF, 1'b1, 1'b0, 8'h00, ST_BYTE}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add_res(input logic [7:0] v, input status_t s);
    step_res[step_n] = '{v, s, 1'b0};
    step_n++;
  endfunction

  function automatic void fail_to(input status_t s);
    add_res(8'h00, s);
    lit_mode = M_DISCARD;
  endfunction

  function automatic void take_digit(input logic [3:0] d);
    logic [24:0] v;
    v = {cp_acc, d};
    if (!cp_huge) begin
      if (v >= CpLimit) cp_huge = 1'b1;
      else cp_acc = v[20:0];
    end
  endfunction

  // Advances the decoder by one input beat and leaves its results in step_res.
  function automatic void unescape_step(input logic [7:0] b, input logic eoi);
    logic       dv;
    logic [3:0] d;
    logic [20:0] u;
    step_n = 0;
    dv = 1'b1;
    d = b[3:0];
    if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) d = b[3:0] + 4'd9;
    else if (!(b >= 8'h30 && b <= 8'h39)) dv = 1'b0;
    if (eoi) begin
      if (lit_mode == M_IDLE) add_res(8'h00, ST_NOQUOTE);
      else if (lit_mode != M_DONE && lit_mode != M_DISCARD) add_res(8'h00, ST_UNTERM);
      lit_mode = M_IDLE;
      hi_nib = '0;
      cp_acc = '0;
      cp_huge = 1'b0;
    end else begin
      case (lit_mode)
        M_IDLE: begin
          if (b == ChQuote) lit_mode = M_BODY;
          else fail_to(ST_NOQUOTE);
        end
        M_BODY: begin
          if (b == ChQuote) begin
            lit_mode = M_DONE;
            add_res(8'h00, ST_CLOSED);
          end else if (b == ChBackslash) begin
            lit_mode = M_ESC;
          end else if (b < ChSpace || b == ChDel) begin
            fail_to(ST_CONTROL);
          end else begin
            add_res(b, ST_BYTE);
          end
        end
        M_ESC: begin
          lit_mode = M_BODY;
          if (b == ChLowT) add_res(ChTab, ST_BYTE);
          else if (b == ChLowN) add_res(ChLf, ST_BYTE);
          else if (b == ChLowR) add_res(ChCr, ST_BYTE);
          else if (b == ChBackslash || b == ChQuote || b == ChApos) add_res(b, ST_BYTE);
          else if (b == ChLowU) lit_mode = M_UOPEN;
          else if (dv) begin
            hi_nib = d;
            lit_mode = M_HEX2;
          end else fail_to(ST_BADESC);
        end
        M_HEX2: begin
          if (!dv) fail_to(ST_BADESC);
          else begin
            lit_mode = M_BODY;
            add_res({hi_nib, d}, ST_BYTE);
          end
        end
        M_UOPEN: begin
          if (b != ChLBrace) fail_to(ST_BADESC);
          else begin
            cp_acc = '0;
            cp_huge = 1'b0;
            lit_mode = M_UFIRST;
          end
        end
        M_UFIRST, M_UUNDER: begin
          if (!dv) fail_to(ST_BADUNI);
          else begin
            take_digit(d);
            lit_mode = M_UDIGITS;
          end
        end
        M_UDIGITS: begin
          if (dv) begin
            take_digit(d);
          end else if (b == ChUnder) begin
            lit_mode = M_UUNDER;
          end else if (b == ChRBrace) begin
            u = cp_acc;
            if (cp_huge || u >= CpLimit || (u >= CpSurrLo && u < CpSurrHi)) begin
              fail_to(ST_RANGE);
            end else begin
              lit_mode = M_BODY;
              if (u < CpOneMax) begin
                add_res(u[7:0], ST_BYTE);
              end else if (u < CpTwoMax) begin
                add_res({3'b110, u[10:6]}, ST_BYTE);
                add_res({2'b10, u[5:0]}, ST_BYTE);
              end else if (u < CpThreeMax) begin
                add_res({4'b1110, u[15:12]}, ST_BYTE);
                add_res({2'b10, u[11:6]}, ST_BYTE);
                add_res({2'b10, u[5:0]}, ST_BYTE);
              end else begin
                add_res({5'b11110, u[20:18]}, ST_BYTE);
                add_res({2'b10, u[17:12]}, ST_BYTE);
                add_res({2'b10, u[11:6]}, ST_BYTE);
                add_res({2'b10, u[5:0]}, ST_BYTE);
              end
            end
          end else begin
            fail_to(ST_BADUNI);
          end
        end
        default: ;
      endcase
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  function automatic void note_mismatch(input string fld, input logic [7:0] want,
                                        input logic [7:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
  endfunction

  always @(posedge clk) begin : check_beats
    beat_t bt;
    res_t  got;
    res_t  want;
    int    k;
    if (!rst) begin
      if (s_tvalid && s_tready && offered_q.size() > 0) begin
        bt = offered_q.pop_front();
        useful_in++;
        unescape_step(bt.ch, bt.eoi);
        if (bt.typed) begin
          want = '{bt.t_byte, bt.t_status, 1'b1};
          decoded_q.insert(decoded_q.size(), want);
        end else begin
          for (k = 0; k < step_n; k++) decoded_q.insert(decoded_q.size(), step_res[k]);
        end
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], status_t'(m_tdata[10:8]), m_tlast};
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected, actual byte %h status %0d last %b",
                   $time, got.out_byte, got.status, got.last);
        end else begin
          want = decoded_q.pop_front();
          if (got.out_byte !== want.out_byte) note_mismatch("out_byte", want.out_byte,
                                                            got.out_byte);
          if (got.status !== want.status) note_mismatch("status", 8'(want.status),
                                                        8'(got.status));
          if (got.last !== want.last) note_mismatch("last", 8'(want.last), 8'(got.last));
        end
      end
    end
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Holds the result side off once for a long stretch so that the block backs up.
  initial begin : stall_results
    int n;
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && useful_in >= 200) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      n = idle_cycles();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8))
        @(posedge clk);
    end
  end

  task automatic send_beat(input beat_t bt, input bit eager);
    int g;
    g = eager ? 0 : idle_cycles();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= bt.ch;
    s_tlast <= bt.eoi;
    offered_q.insert(offered_q.size(), bt);
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic void push_ch(input logic [7:0] c);
    beat_t bt;
    bt = '{c, 1'b0, 1'b0, 8'h00, ST_BYTE};
    literal_q.insert(literal_q.size(), bt);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  // One piece of literal body; a flawed piece usually ends the literal with an error.
  function automatic void add_piece(input bit bad);
    logic [7:0]  c;
    logic [7:0]  u [$];
    logic [31:0] v;
    int          kind;
    int          nd;
    int          extra;
    int          i;
    kind = $urandom_range(0, 9);
    if (!bad && kind <= 4) begin
      do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == ChQuote || c == ChBackslash ||
                                                       c == ChDel);
      push_ch(c);
      return;
    end
    if (!bad && kind <= 6) begin
      push_ch(ChBackslash);
      case ($urandom_range(0, 5))
        0: push_ch(ChLowT);
        1: push_ch(ChLowN);
        2: push_ch(ChLowR);
        3: push_ch(ChBackslash);
        4: push_ch(ChQuote);
        default: push_ch(ChApos);
      endcase
      return;
    end
    if (!bad && kind == 7) begin
      push_ch(ChBackslash);
      push_ch(hex_char(4'($urandom_range(0, 15))));
      push_ch(hex_char(4'($urandom_range(0, 15))));
      return;
    end
    if (bad) begin
      case ($urandom_range(0, 4))
        0: begin
          push_ch(8'($urandom_range(0, 255)));
          return;
        end
        1: begin
          push_ch(ChBackslash);
          push_ch(8'($urandom_range(0, 255)));
          return;
        end
        2: begin
          push_ch(ChBackslash);
          push_ch(hex_char(4'($urandom_range(0, 15))));
          push_ch(8'($urandom_range(0, 255)));
          return;
        end
        3: begin
          push_ch(ChBackslash);
          push_ch(ChLowU);
          push_ch(8'($urandom_range(0, 255)));
          return;
        end
        default: ;
      endcase
    end
    // Unicode escape across all encoding lengths, surrogates and oversized values.
    extra = 0;
    case ($urandom_range(0, 6))
      0: v = $urandom_range(0, 'h7F);
      1: v = $urandom_range('h80, 'h7FF);
      2: v = $urandom_range('h800, 'hFFFF);
      3: v = $urandom_range('hD800, 'hDFFF);
      4: v = $urandom_range('h10000, 'h10FFFF);
      5: begin
        v = $urandom_range('h110000, 'hFFFFFFFF);
        if ($urandom_range(0, 2) == 0) extra = $urandom_range(1, 4);
      end
      default: begin
        case ($urandom_range(0, 12))
          0: v = 'h0;
          1: v = 'h7F;
          2: v = 'h80;
          3: v = 'h7FF;
          4: v = 'h800;
          5: v = 'hFFFF;
          6: v = 'h10000;
          7: v = 'h10FFFF;
          8: v = 'h110000;
          9: v = 'hD7FF;
          10: v = 'hD800;
          11: v = 'hDFFF;
          default: v = 'hE000;
        endcase
      end
    endcase
    nd = 1;
    while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
    if ($urandom_range(0, 3) == 0) nd += $urandom_range(1, 3);
    u.insert(u.size(), ChBackslash);
    u.insert(u.size(), ChLowU);
    u.insert(u.size(), ChLBrace);
    for (i = nd - 1; i >= 0; i--) begin
      u.insert(u.size(), hex_char(i < 8 ? v[4 * i +: 4] : 4'h0));
      if ((i > 0 || extra > 0) && $urandom_range(0, 3) == 0) u.insert(u.size(), ChUnder);
    end
    for (i = 0; i < extra; i++) begin
      u.insert(u.size(), hex_char(4'($urandom_range(0, 15))));
      if (i < extra - 1 && $urandom_range(0, 3) == 0) u.insert(u.size(), ChUnder);
    end
    if (u[u.size() - 1] == ChUnder) u.delete(u.size() - 1);
    u.insert(u.size(), ChRBrace);
    if (bad) begin
      case ($urandom_range(0, 4))
        0: u[$urandom_range(2, u.size() - 1)] = 8'($urandom_range(0, 255));
        1: u.insert($urandom_range(3, u.size() - 1), ChUnder);
        2: u.delete(u.size() - 1);
        3: begin
          u.delete();
          u.insert(u.size(), ChBackslash);
          u.insert(u.size(), ChLowU);
          u.insert(u.size(), ChLBrace);
          u.insert(u.size(), ChRBrace);
        end
        default: begin
          u.delete();
          u.insert(u.size(), ChBackslash);
          u.insert(u.size(), ChLowU);
          u.insert(u.size(), ChLBrace);
          u.insert(u.size(), ChUnder);
          u.insert(u.size(), hex_char(4'($urandom_range(0, 15))));
          u.insert(u.size(), ChRBrace);
        end
      endcase
    end
    foreach (u[j]) push_ch(u[j]);
  endfunction

  task automatic send_literal();
    flaw_t      flaw;
    int         npieces;
    int         bad_at;
    int         i;
    bit         burst;
    logic [7:0] c;
    beat_t      bt;
    literal_q.delete();
    flaw = ($urandom_range(0, 99) < 20) ? flaw_t'($urandom_range(1, 3)) : FLAW_NONE;
    npieces = (flaw == FLAW_NO_QUOTE) ? $urandom_range(0, 2) :
              (flaw == FLAW_BAD_PIECE) ? $urandom_range(1, 12) : $urandom_range(0, 12);
    bad_at = (flaw == FLAW_BAD_PIECE) ? $urandom_range(0, npieces - 1) : -1;
    burst = ($urandom_range(0, 3) == 0);
    if (flaw == FLAW_NO_QUOTE) begin
      do c = 8'($urandom_range(0, 255)); while (c == ChQuote);
      push_ch(c);
    end else begin
      push_ch(ChQuote);
    end
    for (i = 0; i < npieces; i++) add_piece(i == bad_at);
    if (flaw != FLAW_OPEN_END) begin
      push_ch(ChQuote);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) push_ch(8'($urandom_range(0, 255)));
      end
    end
    bt = '{8'($urandom_range(0, 255)), 1'b1, 1'b0, 8'h00, ST_BYTE};
    literal_q.insert(literal_q.size(), bt);
    foreach (literal_q[j]) send_beat(literal_q[j], burst);
  endtask

  initial begin : run_stimulus
    int i;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < 28; i++) send_beat(directed_rows[i], 1'b0);
    while (useful_in < UsefulItems) send_literal();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
